>>> rtl/hkra_pkg.sv
// Shared types, constants and helper functions for the HID keyboard report
// to ASCII translator. No dependencies; every other file but the checker imports this package.
package hkra_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int SLOT_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int MAP_SIZE    = 57;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SHIFT_BITS  = 8'h22;
  localparam logic [7:0] CTRL_BITS   = 8'h11;
  localparam logic [7:0] ARROW_FIRST = 8'h4F;
  localparam logic [7:0] ARROW_LAST  = 8'h52;
  localparam logic [7:0] MIN_LENGTH  = 8'd3;

  localparam logic [6:0] ESC_CHAR  = 7'h1B;
  localparam logic [6:0] CSI_CHAR  = 7'h5B;
  localparam logic [6:0] LOWER_A   = 7'h61;
  localparam logic [6:0] LOWER_Z   = 7'h7A;
  localparam logic [6:0] UPPER_A   = 7'h41;
  localparam logic [6:0] UPPER_Z   = 7'h5A;
  localparam logic [6:0] LOWER_OFS = 7'd96;
  localparam logic [6:0] UPPER_OFS = 7'd64;

  localparam logic [6:0] MAP_PLAIN [0:MAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h00, 7'h00,
    7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69,
    7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0D, 7'h1B, 7'h7F, 7'h09, 7'h20,
    7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
    7'h00, 7'h3B, 7'h27, 7'h60,
    7'h2C, 7'h2E, 7'h2F
  };

  localparam logic [6:0] MAP_SHIFTED [0:MAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h00, 7'h00,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h0D, 7'h1B, 7'h7F, 7'h09, 7'h20,
    7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
    7'h00, 7'h3A, 7'h22, 7'h7E,
    7'h3C, 7'h3E, 7'h3F
  };

  typedef logic [SLOT_W-1:0]         slot_idx_t;
  typedef logic [KEY_SLOTS-1:0]      slot_mask_t;
  typedef logic [KEY_SLOTS-1:0][7:0] slot_bytes_t;

  // One classified key slot: an arrow expands to three characters, with the
  // final letter held in ch.
  typedef struct packed {
    logic       vld;
    logic       arrow;
    logic [6:0] ch;
  } token_t;

  typedef token_t [KEY_SLOTS-1:0] entry_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic avail;
  } queue_ctl_t;

  typedef enum logic [2:0] {
    SEQ_ESC   = 3'b001,
    SEQ_CSI   = 3'b010,
    SEQ_FINAL = 3'b100
  } arrow_seq_t;

  function automatic logic [6:0] arrow_final(input logic [1:0] sel);
    logic [6:0] ch;
    unique case (sel)
      2'd0: ch = 7'h43;
      2'd1: ch = 7'h44;
      2'd2: ch = 7'h42;
      2'd3: ch = 7'h41;
      default: ch = 7'h41;
    endcase
    return ch;
  endfunction

  function automatic slot_mask_t valid_mask(input entry_t e);
    slot_mask_t m;
    for (int i = 0; i < KEY_SLOTS; i++) m[i] = e[i].vld;
    return m;
  endfunction

  function automatic slot_idx_t first_slot(input slot_mask_t m);
    slot_idx_t idx;
    idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic slot_idx_t next_slot(input slot_mask_t m, input slot_idx_t cur);
    slot_idx_t idx;
    idx = cur;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (m[i] && (i > int'(cur))) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic any_after(input slot_mask_t m, input slot_idx_t cur);
    logic found;
    found = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (m[i] && (i > int'(cur))) found = 1'b1;
    end
    return found;
  endfunction

endpackage

>>> rtl/hid_keyboard_report_to_ascii.sv
// Top level of the boot-keyboard report to ASCII translator.
// Depends on hkra_pkg, hkra_front, hkra_queue and hkra_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   report  | in_valid / in_stall  | modifiers, key_slot_0..5, report_length
//   chars   | out_valid / out_stall| char_code, last_of_run
//
// A report is taken when the two-entry queue has room; its characters then
// leave at one per cycle while out_stall is low, up to 18 per report, all
// through the single output port of the back end.
// Reset (rst, synchronous) clears the remembered keys, the queue and the back end.
// A stall on the character side fills the queue and only then stalls reports.
module hid_keyboard_report_to_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_slot_0,
  input  logic [7:0] key_slot_1,
  input  logic [7:0] key_slot_2,
  input  logic [7:0] key_slot_3,
  input  logic [7:0] key_slot_4,
  input  logic [7:0] key_slot_5,
  input  logic [7:0] report_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_code,
  output logic       last_of_run
);
  import hkra_pkg::*;

  slot_bytes_t key_in;
  entry_t      push_data;
  entry_t      pop_data;
  queue_ctl_t  ctl_to_q;
  queue_ctl_t  ctl_from_q;
  logic        q_push;
  logic        q_pop;

  // Gather the six slot ports into one vector, slot 0 first.
  assign key_in = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};

  // The front compares each slot against the previous report and turns new
  // key presses into tokens; reports that yield no token are not queued, but
  // those of at least MIN_LENGTH still update the remembered keys.
  hkra_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .modifiers     (modifiers),
    .key_in        (key_in),
    .report_length (report_length),
    .q_full        (ctl_from_q.full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  always_comb begin
    ctl_to_q      = '0;
    ctl_to_q.push = q_push;
    ctl_to_q.pop  = q_pop;
  end

  // The queue decouples the two halves so that the front can keep taking
  // requests while the back is still sending characters of an earlier one.
  hkra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .pop_data  (pop_data),
    .ctl_in    (ctl_to_q),
    .ctl_out   (ctl_from_q)
  );

  // The back walks the tokens of one report in slot order; the last
  // character of the report carries last_of_run.
  hkra_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (ctl_from_q.avail),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last_of_run (last_of_run)
  );

endmodule

>>> rtl/hkra_front.sv
// Front end: accepts reports, keeps the previous key codes and classifies
// every slot into a token. Depends on hkra_pkg.
module hkra_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           modifiers,
  input  hkra_pkg::slot_bytes_t key_in,
  input  logic [7:0]           report_length,
  input  logic                 q_full,
  output logic                 q_push,
  output hkra_pkg::entry_t     q_data
);
  import hkra_pkg::*;

  slot_bytes_t prev_keys;
  slot_bytes_t cur;
  slot_mask_t  seen;
  logic        shifted;
  logic        ctrl;
  logic        accept;
  logic        long_report;

  function automatic token_t classify(input logic [7:0] code, input logic was_down,
                                      input logic sh, input logic ct);
    token_t     t;
    logic [6:0] ch;
    t  = '0;
    ch = '0;
    if ((code != 8'd0) && !was_down) begin
      if ((code >= ARROW_FIRST) && (code <= ARROW_LAST)) begin
        t.vld   = 1'b1;
        t.arrow = 1'b1;
        t.ch    = arrow_final(2'(code - ARROW_FIRST));
      end else begin
        if (code < 8'(MAP_SIZE)) ch = sh ? MAP_SHIFTED[code[5:0]] : MAP_PLAIN[code[5:0]];
        if (ct && (ch >= LOWER_A) && (ch <= LOWER_Z)) ch = ch - LOWER_OFS;
        if (ct && (ch >= UPPER_A) && (ch <= UPPER_Z)) ch = ch - UPPER_OFS;
        t.ch  = ch;
        t.vld = (ch != 7'd0);
      end
    end
    return t;
  endfunction

  assign shifted     = |(modifiers & SHIFT_BITS);
  assign ctrl        = |(modifiers & CTRL_BITS);
  assign in_stall    = q_full;
  assign accept      = in_valid && !in_stall;
  assign long_report = (report_length >= MIN_LENGTH);

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      // Slot i lies inside the report only when i + 1 is below the length.
      cur[i]  = ({1'b0, report_length} > 9'(i + 1)) ? key_in[i] : 8'd0;
      seen[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_keys[j] == cur[i]) seen[i] = 1'b1;
      end
      q_data[i] = classify(cur[i], seen[i], shifted, ctrl);
    end
  end

  assign q_push = accept && long_report && (|valid_mask(q_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_keys <= '0;
    end else if (accept && long_report) begin
      prev_keys <= cur;
    end
  end

endmodule

>>> rtl/hkra_queue.sv
// Short queue of classified reports between the front and the back end.
// Depends on hkra_pkg.
module hkra_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  hkra_pkg::entry_t       push_data,
  output hkra_pkg::entry_t       pop_data,
  input  hkra_pkg::queue_ctl_t   ctl_in,
  output hkra_pkg::queue_ctl_t   ctl_out
);
  import hkra_pkg::*;

  entry_t             store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign do_push = ctl_in.push && (count != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = ctl_in.pop && (count != '0);

  always_comb begin
    ctl_out       = '0;
    ctl_out.full  = (count == QCNT_W'(QUEUE_DEPTH));
    ctl_out.avail = (count != '0);
  end

  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/hkra_back.sv
// Back end: walks the tokens of one queued report and sends one character
// per cycle unless stalled, expanding arrows to escape sequences. Depends on hkra_pkg.
module hkra_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_avail,
  input  hkra_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       char_code,
  output logic             last_of_run
);
  import hkra_pkg::*;

  logic       busy;
  entry_t     entry;
  slot_idx_t  idx;
  arrow_seq_t seq;
  slot_mask_t mask;
  token_t     tok;
  logic       token_done;
  logic       last;
  logic       out_accept;

  assign mask       = valid_mask(entry);
  assign tok        = entry[idx];
  assign token_done = !tok.arrow || (seq == SEQ_FINAL);
  assign last       = token_done && !any_after(mask, idx);
  assign out_valid  = busy;
  assign out_accept = busy && !out_stall;
  assign last_of_run = last;
  assign q_pop      = q_avail && (!busy || (out_accept && last));

  always_comb begin
    if (tok.arrow) begin
      unique case (seq)
        SEQ_ESC:   char_code = ESC_CHAR;
        SEQ_CSI:   char_code = CSI_CHAR;
        SEQ_FINAL: char_code = tok.ch;
        default:   char_code = tok.ch;
      endcase
    end else begin
      char_code = tok.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) entry <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      seq  <= SEQ_ESC;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= first_slot(valid_mask(q_data));
      seq  <= SEQ_ESC;
    end else if (out_accept) begin
      if (last) begin
        busy <= 1'b0;
      end else if (!token_done) begin
        seq <= (seq == SEQ_ESC) ? SEQ_CSI : SEQ_FINAL;
      end else begin
        idx <= next_slot(mask, idx);
        seq <= SEQ_ESC;
      end
    end
  end

endmodule

>>> rtl/hkra_checker.sv
// Port-level checker for the report to ASCII translator, bound to the top
// level. Depends only on the top level's ports.
module hkra_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] modifiers,
  input logic [7:0] key_slot_0,
  input logic [7:0] key_slot_1,
  input logic [7:0] key_slot_2,
  input logic [7:0] key_slot_3,
  input logic [7:0] key_slot_4,
  input logic [7:0] key_slot_5,
  input logic [7:0] report_length,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] char_code,
  input logic       last_of_run
);

  // No character is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("character pending after reset");

  // A stalled character holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_of_run))
    else $error("stalled character changed");

  // A zero character is never sent.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code != 7'd0)
    else $error("zero character sent");

  // Characters of one request follow each other without a gap.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside a run");

  // Requests are only held off while characters are waiting to leave.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("request stalled with no character pending");

endmodule

bind hid_keyboard_report_to_ascii hkra_checker u_hkra_checker (.*);

>>> test/tb.sv
// Self-checking testbench for hid_keyboard_report_to_ascii.
// Holds its own translator model in a small scoreboard class; needs only hkra_pkg
// and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hkra_pkg::*;

  // A run ends as a failure once this many cycles pass with no request and no
  // character accepted. The longest quiet stretch is the deliberate receiver
  // hold-off below, plus random stalls on top of it.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_REPORTS = 95;
  localparam int DRAIN_CYCLES = 40;

  // Scoreboard: predicts the characters of each accepted report and matches
  // them, in order, against the characters that leave the block.
  class char_scoreboard;
    logic [7:0] held_keys [KEY_SLOTS];
    logic [6:0] pending_chars [$];
    logic       pending_last [$];
    int         failures;
    string      plain_map;
    string      shifted_map;
    string      arrow_map;

    function new();
      foreach (held_keys[i]) held_keys[i] = 8'h00;
      failures = 0;
      // Usage codes 0 to 56; the dots at 0 to 3 and at 50 stand for entries that yield nothing.
      plain_map   = "....abcdefghijklmnopqrstuvwxyz1234567890\015\033\177\011 -=[]\\.;'`,./";
      shifted_map = "....ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()\015\033\177\011 _+{}|.:\"~<>?";
      arrow_map   = "CDBA";
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void push_char(logic [6:0] ch);
      pending_chars.push_back(ch);
      pending_last.push_back(1'b0);
    endfunction

    function void note_report(logic [7:0] mods, logic [5:0][7:0] slots,
                              logic [7:0] len);
      logic [7:0] cur [KEY_SLOTS];
      logic       shift;
      logic       ctrl;
      logic [6:0] ch;
      bit         seen;
      int         start;
      if (len < MIN_LENGTH) return;
      start = pending_chars.size();
      shift = |(mods & SHIFT_BITS);
      ctrl  = |(mods & CTRL_BITS);
      foreach (cur[i]) cur[i] = (i < 6 && i + 1 < int'(len)) ? slots[i] : 8'h00;
      foreach (cur[i]) begin
        if (cur[i] == 8'h00) continue;
        seen = 1'b0;
        foreach (held_keys[j]) if (held_keys[j] == cur[i]) seen = 1'b1;
        if (seen) continue;
        if (cur[i] >= ARROW_FIRST && cur[i] <= ARROW_LAST) begin
          push_char(ESC_CHAR);
          push_char(CSI_CHAR);
          push_char(7'(arrow_map[int'(cur[i] - ARROW_FIRST)]));
          continue;
        end
        // Codes below 4, the non-US hash slot and everything past the table
        // give nothing.
        if (cur[i] < 8'd4 || cur[i] == 8'h32 || cur[i] >= MAP_SIZE) ch = 7'h00;
        else ch = shift ? 7'(shifted_map[int'(cur[i])]) : 7'(plain_map[int'(cur[i])]);
        if (ctrl && ch >= LOWER_A && ch <= LOWER_Z) ch = ch - LOWER_OFS;
        else if (ctrl && ch >= UPPER_A && ch <= UPPER_Z) ch = ch - UPPER_OFS;
        if (ch != 7'h00) push_char(ch);
      end
      held_keys = cur;
      if (pending_chars.size() > start) pending_last[pending_last.size() - 1] = 1'b1;
    endfunction

    function void check_char(logic [6:0] code, logic last);
      logic [6:0] want_code;
      logic       want_last;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0h, last_of_run %0b", code, last);
        failures++;
        return;
      end
      want_code = pending_chars.pop_front();
      want_last = pending_last.pop_front();
      if (code !== want_code) begin
        $error("char_code: expected %0h, actual %0h", want_code, code);
        failures++;
      end
      if (last !== want_last) begin
        $error("last_of_run: expected %0b, actual %0b", want_last, last);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] modifiers = 8'h00;
  logic [7:0] key_slot_0 = 8'h00;
  logic [7:0] key_slot_1 = 8'h00;
  logic [7:0] key_slot_2 = 8'h00;
  logic [7:0] key_slot_3 = 8'h00;
  logic [7:0] key_slot_4 = 8'h00;
  logic [7:0] key_slot_5 = 8'h00;
  logic [7:0] report_length = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] char_code;
  logic       last_of_run;

  char_scoreboard sb;

  // Idle rates in percent for each side, set by the stimulus per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The receiver hold-off: the stimulus raises hold_req once, and the receiver
  // process then counts the stretch out on its own.
  logic hold_req = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  int   quiet_cycles = 0;

  // Key codes of the last request sent, so that random reports can keep keys
  // held the way a real keyboard does.
  logic [7:0] last_slots [6];

  hid_keyboard_report_to_ascii dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .modifiers    (modifiers),
    .key_slot_0   (key_slot_0),
    .key_slot_1   (key_slot_1),
    .key_slot_2   (key_slot_2),
    .key_slot_3   (key_slot_3),
    .key_slot_4   (key_slot_4),
    .key_slot_5   (key_slot_5),
    .report_length(report_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character side. A stall is drawn anew every cycle, except during the one
  // long hold-off, which lets the queue fill and pushes back on requests.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor. Both handshakes are sampled at the same edge: the request first,
  // so the scoreboard always knows a report before any of its characters.
  // The watchdog also lives here, counting edges at which nothing moved.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_report(modifiers, {key_slot_5, key_slot_4, key_slot_3,
                                   key_slot_2, key_slot_1, key_slot_0},
                       report_length);
      if (out_valid && !out_stall) sb.check_char(char_code, last_of_run);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Offers one report and returns at the edge where the block takes it. The
  // sender may first idle for a random number of cycles with valid low; the
  // payload then holds still for as long as the block stalls.
  task automatic send_report(input logic [7:0] m, input logic [7:0] k0,
                             input logic [7:0] k1, input logic [7:0] k2,
                             input logic [7:0] k3, input logic [7:0] k4,
                             input logic [7:0] k5, input logic [7:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    modifiers     <= m;
    key_slot_0    <= k0;
    key_slot_1    <= k1;
    key_slot_2    <= k2;
    key_slot_3    <= k3;
    key_slot_4    <= k4;
    key_slot_5    <= k5;
    report_length <= len;
    last_slots = '{k0, k1, k2, k3, k4, k5};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 9))
      7:       return 8'($urandom_range(ARROW_FIRST, ARROW_LAST));
      8:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(4, MAP_SIZE - 1));
    endcase
  endfunction

  // One random report. Most look like real typing: mostly full-length reports where
  // some keys stay held, some are released and new ones come down, under the
  // usual modifier combinations or a random one. The rest is raw noise over every field.
  task automatic random_report(output bit counted);
    logic [7:0] m;
    logic [7:0] len;
    logic [7:0] k [6];
    int         r;
    if ($urandom_range(0, 99) < 15) begin
      m   = 8'($urandom);
      len = 8'($urandom);
      foreach (k[i]) k[i] = 8'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       m = 8'h00;
        1:       m = 8'h02;
        2:       m = 8'h20;
        3:       m = 8'h01;
        4:       m = 8'h12;
        default: m = 8'($urandom);
      endcase
      len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 7)) : 8'd8;
      foreach (k[i]) begin
        r = $urandom_range(0, 9);
        if (r < 4) k[i] = last_slots[i];
        else if (r < 6) k[i] = 8'h00;
        else k[i] = pick_key();
      end
    end
    send_report(m, k[0], k[1], k[2], k[3], k[4], k[5], len);
    counted = (len >= MIN_LENGTH);
  endtask

  // Waits at least one edge, so the monitor has seen the last request, and
  // then until every predicted character has left the block.
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    bit counted;
    int sent;
    sb = new();
    foreach (last_slots[i]) last_slots[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 71;

    // Directed reports. Comments give the characters each one should yield.
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8); // nothing
    send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd8); // abcdef
    send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd8); // all held
    // Left shift, then right shift, over letters, digits and punctuation.
    send_report(8'h02, 8'h04, 8'h1D, 8'h1E, 8'h27, 8'h2D, 8'h31, 8'd8);
    send_report(8'h20, 8'h2E, 8'h2F, 8'h30, 8'h32, 8'h33, 8'h34, 8'd8);
    // Plain punctuation, enter and escape; then delete, tab and space.
    send_report(8'h00, 8'h35, 8'h36, 8'h37, 8'h38, 8'h28, 8'h29, 8'd8);
    send_report(8'h00, 8'h2A, 8'h2B, 8'h2C, 8'h33, 8'h34, 8'h1E, 8'd8);
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8);
    // The same arrow in every slot: six escapes, the longest run a report has.
    send_report(8'h00, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'd8);
    send_report(8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h00, 8'h00, 8'd8);
    // Ctrl on letters turns them into control codes; digits and '[' pass.
    send_report(8'h01, 8'h04, 8'h0A, 8'h1D, 8'h1E, 8'h2F, 8'h00, 8'd8);
    send_report(8'h12, 8'h05, 8'h0B, 8'h1C, 8'h1F, 8'h30, 8'h2C, 8'd8);
    // Codes without a character give nothing but are still remembered.
    send_report(8'h00, 8'h01, 8'h02, 8'h03, 8'h32, 8'h39, 8'hFF, 8'd8);
    send_report(8'h00, 8'hFF, 8'h39, 8'h04, 8'h00, 8'h00, 8'h00, 8'd8);
    // Short reports are dropped and leave the held keys alone.
    send_report(8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8);
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd2);
    send_report(8'hFF, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'd0);
    send_report(8'hFF, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'd1);
    send_report(8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8);
    // Truncation: each longer report uncovers two more slots.
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8);
    send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd3);
    send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd5);
    send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd7);
    // A new code in several slots yields a character for each of them.
    send_report(8'h00, 8'h0A, 8'h0A, 8'h00, 8'h0A, 8'h00, 8'h00, 8'd8);
    // Extreme modifier and length values.
    send_report(8'hFF, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'hFF);
    send_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Random reports in three phases: sender idling lightly and receiver
    // heavily, then the reverse, then both running flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // The receiver now holds off for a long stretch while reports keep
          // coming, so the queue fills and the block stalls its input.
          hold_req <= 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_REPORTS) begin
        random_report(counted);
        if (counted) sent++;
      end
      if (phase == 0) begin
        // The sender pauses until every character so far has come out.
        in_valid <= 1'b0;
        wait_drained();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    // Anything arriving after this point has no prediction and fails.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hkra_pkg.sv
rtl/hkra_front.sv
rtl/hkra_queue.sv
rtl/hkra_back.sv
rtl/hid_keyboard_report_to_ascii.sv
rtl/hkra_checker.sv
test/tb.sv
